// ===== sv/sle_pkg.sv =====
// -----------------------------------------------------------------------------
// sle_pkg : shared types and constants for the serial line editor FIFO
// Character codes, operation and status codes, and the result record.
// -----------------------------------------------------------------------------
package sle_pkg;

	localparam int FIFO_DEPTH_DEF = 64;
	localparam int LINE_SIZE_DEF  = 64;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_DEL   = 8'h7F;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef enum logic [1:0] {
		OP_PUSH    = 2'd0,
		OP_SERVICE = 2'd1,
		OP_READ    = 2'd2,
		OP_UNUSED  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_NONE      = 3'd0,
		ST_LINE_DONE = 3'd1,
		ST_LINE_OVF  = 3'd2,
		ST_FIFO_OVF  = 3'd3,
		ST_EMPTY     = 3'd4,
		ST_DROPPED   = 3'd5
	} status_t;

	typedef struct packed {
		logic [7:0] echo_char;
		logic       echo_valid;
		status_t    status;
		logic [5:0] line_length;
		logic [7:0] line_byte;
	} res_t;

	// Result slots of one item, emitted lowest first
	localparam int NUM_SLOTS = 6;
	localparam int SL_OVF    = 0;
	localparam int SL_ECHO   = 1;
	localparam int SL_E2     = 2;
	localparam int SL_E3     = 3;
	localparam int SL_E4     = 4;
	localparam int SL_STAT   = 5;

endpackage

// ===== sv/serial_line_editor_fifo_unit.sv =====
// -----------------------------------------------------------------------------
// serial_line_editor_fifo_unit : receive FIFO with terminal line editor
//
// Channel  Dir  Handshake            Payload
// s_*      in   s_tvalid/s_tready    tdata: char_in[7:0] read_index[13:8]; tuser: operation[1:0]
// m_*      out  m_tvalid/m_tready    tdata: echo_char[7:0] line_length[13:8] line_byte[21:14];
//                                    tuser: echo_valid[0] status[3:1]; tlast on final result
// cfg_*    in   cfg_valid/cfg_ready  echo_enable, always ready
//
// An item yields n = 1..5 results: the memory read on accept, the decide step, then
// one result per cycle into the output register while m_tready does not stall it.
// The FIFO and line store are single-port-write RAMs with registered reads.
// Reset is asynchronous and clears pointers, flags and control; no RAM sweep.
// A stalled m_tready holds the output register and the pending results.
// -----------------------------------------------------------------------------
module serial_line_editor_fifo_unit #(
	parameter int FIFO_DEPTH = sle_pkg::FIFO_DEPTH_DEF,
	parameter int LINE_SIZE  = sle_pkg::LINE_SIZE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // char_in[7:0], read_index[13:8]
	input  logic [1:0]  s_tuser,   // operation[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // echo_char[7:0], line_length[13:8], line_byte[21:14]
	output logic [3:0]  m_tuser,   // echo_valid[0], status[3:1]
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data   // echo_enable
);

	localparam int PW = $clog2(FIFO_DEPTH);
	localparam int LW = $clog2(LINE_SIZE);
	localparam int NS = sle_pkg::NUM_SLOTS;
	localparam int SW = $clog2(NS);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_DECIDE = 3'b010,
		S_EMIT   = 3'b100
	} state_t;

	state_t state_q;

	logic [7:0] fifo_mem [FIFO_DEPTH];
	logic [7:0] line_mem [LINE_SIZE];

	logic [PW-1:0] wptr_q, rptr_q, wptr_d, rptr_d;
	logic [LW-1:0] pos_q, pos_d;
	logic          ovf_q, ovf_d;
	logic          echo_en_q;

	sle_pkg::op_t  op_q;
	logic [7:0]    char_q;
	logic          idx_ok_q;
	logic [7:0]    fifo_rd_s1, line_rd_s1;

	sle_pkg::res_t slot_q [NS];
	sle_pkg::res_t slot_d [NS];
	logic [NS-1:0] pend_q, pend_d;

	sle_pkg::res_t out_q;
	logic          out_valid_q, out_last_q;

	logic          accept, load, fifo_we, line_we;
	logic [31:0]   idx_w;
	logic [LW-1:0] line_ra, pos_eff;
	logic [PW-1:0] wnext, rnext;
	logic          have, is_nl, is_bs, pos_nz;
	logic [31:0]   pos_w;
	logic [SW-1:0] pick_idx;
	logic [NS-1:0] pick_oh, rest;

	assign accept    = s_tvalid && s_tready;
	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;

	assign idx_w   = 32'(s_tdata[13:8]);
	assign line_ra = idx_w[LW-1:0];

	assign wnext = (wptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
	assign rnext = (rptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
	assign have  = (wptr_q != rptr_q);

	// a pending overflow clears the line before the popped byte is edited
	assign pos_eff = ovf_q ? '0 : pos_q;
	assign pos_nz  = (pos_eff != '0);
	assign pos_w   = 32'(pos_eff);
	assign is_nl   = (fifo_rd_s1 == sle_pkg::CH_CR) || (fifo_rd_s1 == sle_pkg::CH_LF);
	assign is_bs   = (fifo_rd_s1 == sle_pkg::CH_BS) || (fifo_rd_s1 == sle_pkg::CH_DEL);

	always_comb begin
		for (int i = 0; i < NS; i++) begin
			slot_d[i] = '0;
		end
		pend_d  = '0;
		wptr_d  = wptr_q;
		rptr_d  = rptr_q;
		ovf_d   = ovf_q;
		pos_d   = pos_q;
		fifo_we = 1'b0;
		line_we = 1'b0;
		slot_d[sle_pkg::SL_OVF].status      = sle_pkg::ST_FIFO_OVF;
		slot_d[sle_pkg::SL_ECHO].echo_char  = fifo_rd_s1;
		slot_d[sle_pkg::SL_ECHO].echo_valid = 1'b1;
		slot_d[sle_pkg::SL_E2].echo_valid   = 1'b1;
		slot_d[sle_pkg::SL_E3].echo_valid   = 1'b1;
		slot_d[sle_pkg::SL_E4].echo_valid   = 1'b1;
		slot_d[sle_pkg::SL_E2].echo_char    = is_nl ? sle_pkg::CH_CR : sle_pkg::CH_BS;
		slot_d[sle_pkg::SL_E3].echo_char    = is_nl ? sle_pkg::CH_LF : sle_pkg::CH_SPACE;
		slot_d[sle_pkg::SL_E4].echo_char    = sle_pkg::CH_BS;
		case (op_q)
			sle_pkg::OP_PUSH: begin
				pend_d[sle_pkg::SL_STAT] = 1'b1;
				if (wnext == rptr_q) begin
					ovf_d = 1'b1;
					slot_d[sle_pkg::SL_STAT].status = sle_pkg::ST_DROPPED;
				end else begin
					fifo_we = 1'b1;
					wptr_d  = wnext;
				end
			end
			sle_pkg::OP_SERVICE: begin
				if (have) begin
					rptr_d = rnext;
				end
				if (ovf_q) begin
					wptr_d = '0;
					rptr_d = '0;
					ovf_d  = 1'b0;
					pos_d  = '0;
					pend_d[sle_pkg::SL_OVF] = 1'b1;
				end
				if (have) begin
					pend_d[sle_pkg::SL_ECHO] = echo_en_q;
					if (is_nl) begin
						pos_d = '0;
						pend_d[sle_pkg::SL_E2] = echo_en_q;
						pend_d[sle_pkg::SL_E3] = echo_en_q;
						if (pos_nz) begin
							pend_d[sle_pkg::SL_STAT] = 1'b1;
							slot_d[sle_pkg::SL_STAT].status      = sle_pkg::ST_LINE_DONE;
							slot_d[sle_pkg::SL_STAT].line_length = pos_w[5:0];
						end
					end else if (is_bs) begin
						if (pos_nz) begin
							pos_d = pos_eff - 1'b1;
							pend_d[sle_pkg::SL_E2] = echo_en_q;
							pend_d[sle_pkg::SL_E3] = echo_en_q;
							pend_d[sle_pkg::SL_E4] = echo_en_q;
						end
					end else if (pos_eff < LW'(LINE_SIZE - 1)) begin
						line_we = 1'b1;
						pos_d   = pos_eff + 1'b1;
					end else begin
						pos_d = '0;
						pend_d[sle_pkg::SL_STAT] = 1'b1;
						slot_d[sle_pkg::SL_STAT].status = sle_pkg::ST_LINE_OVF;
					end
				end else if (!ovf_q) begin
					pend_d[sle_pkg::SL_STAT] = 1'b1;
					slot_d[sle_pkg::SL_STAT].status = sle_pkg::ST_EMPTY;
				end
			end
			sle_pkg::OP_READ: begin
				pend_d[sle_pkg::SL_STAT] = 1'b1;
				slot_d[sle_pkg::SL_STAT].line_byte = idx_ok_q ? line_rd_s1 : 8'h00;
			end
			default: begin
				pend_d[sle_pkg::SL_STAT] = 1'b1;
			end
		endcase
		// nothing else to report: one blank result
		if (pend_d == '0) begin
			pend_d[sle_pkg::SL_STAT] = 1'b1;
		end
	end

	// lowest pending slot goes out next
	always_comb begin
		pick_idx = '0;
		for (int i = NS - 1; i >= 0; i--) begin
			if (pend_q[i]) begin
				pick_idx = SW'(i);
			end
		end
		pick_oh = NS'(1) << pick_idx;
		rest    = pend_q & ~pick_oh;
	end

	assign load = (state_q == S_EMIT) && (!out_valid_q || m_tready);

	// RAMs: read ports sampled on accept, writes from the decide cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			fifo_rd_s1 <= fifo_mem[rptr_q];
			line_rd_s1 <= line_mem[line_ra];
		end
		if (state_q == S_DECIDE && fifo_we) begin
			fifo_mem[wptr_q] <= char_q;
		end
		if (state_q == S_DECIDE && line_we) begin
			line_mem[pos_eff] <= fifo_rd_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= sle_pkg::op_t'(s_tuser);
			char_q   <= s_tdata[7:0];
			idx_ok_q <= (idx_w < LINE_SIZE);
		end
		if (state_q == S_DECIDE) begin
			for (int i = 0; i < NS; i++) begin
				slot_q[i] <= slot_d[i];
			end
		end
		if (load) begin
			out_q      <= slot_q[pick_idx];
			out_last_q <= (rest == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wptr_q      <= '0;
			rptr_q      <= '0;
			pos_q       <= '0;
			ovf_q       <= 1'b0;
			echo_en_q   <= 1'b1;
			pend_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				echo_en_q <= cfg_data;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					wptr_q  <= wptr_d;
					rptr_q  <= rptr_d;
					pos_q   <= pos_d;
					ovf_q   <= ovf_d;
					pend_q  <= pend_d;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (load) begin
						pend_q <= rest;
						if (rest == '0) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {2'b00, out_q.line_byte, out_q.line_length, out_q.echo_char};
	assign m_tuser  = {out_q.status, out_q.echo_valid};

endmodule

// ===== sv/sle_checker.sv =====
// -----------------------------------------------------------------------------
// sle_checker : port-level checks for the serial line editor FIFO
// Watches the stream ports over time; bound to the top level below.
// -----------------------------------------------------------------------------
module sle_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic [3:0]  m_tuser,
	input logic        m_tlast
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result changed under stall");

	// one item in flight: no accept right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in flight");

	// echo character is zero unless flagged, and echoes carry no status
	a_echo_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser[0] ? (m_tuser[3:1] == sle_pkg::ST_NONE)
			: (m_tdata[7:0] == 8'h00)))
		else $error("echo fields inconsistent");

	// a length only comes with a completed line
	a_len_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[3:1] != sle_pkg::ST_LINE_DONE) |-> (m_tdata[13:8] == 6'd0))
		else $error("line length outside line complete");

endmodule

bind serial_line_editor_fifo_unit sle_checker u_sle_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
